@@ rtl/core/ms1k_pkg.sv @@
// ----------------------------------------------------------------------------
// ms1k_pkg
// Types, constants and helpers for the spelled-digit SHA-1 key block.
// ----------------------------------------------------------------------------
package ms1k_pkg;

  localparam int KeyHexCharsDefault = 26;
  localparam logic [31:0] MacOffset = 32'h0100_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_BUILD,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic digit_step;
    logic build;
    logic block_init;
    logic round_step;
    logic add_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic digits_done;
    logic rounds_done;
    logic second_block;
  } stat_t;

  function automatic logic [39:0] word_bytes(input logic [3:0] d);
    case (d)
      4'd0: word_bytes = {"Zero", 8'h00};
      4'd1: word_bytes = {"One", 16'h0000};
      4'd2: word_bytes = {"Two", 16'h0000};
      4'd3: word_bytes = "Three";
      4'd4: word_bytes = {"Four", 8'h00};
      4'd5: word_bytes = {"Five", 8'h00};
      4'd6: word_bytes = {"Six", 16'h0000};
      4'd7: word_bytes = "Seven";
      4'd8: word_bytes = "Eight";
      4'd9: word_bytes = {"Nine", 8'h00};
      default: word_bytes = '0;
    endcase
  endfunction

  function automatic logic [2:0] word_len(input logic [3:0] d);
    case (d)
      4'd0, 4'd4, 4'd5, 4'd9: word_len = 3'd4;
      4'd1, 4'd2, 4'd6: word_len = 3'd3;
      4'd3, 4'd7, 4'd8: word_len = 3'd5;
      default: word_len = 3'd0;
    endcase
  endfunction

endpackage

@@ rtl/core/ms1k_ctrl.sv @@
// ----------------------------------------------------------------------------
// ms1k_ctrl
// Sequencer: digit spelling, message build, two hash blocks, output.
// ----------------------------------------------------------------------------
module ms1k_ctrl
  import ms1k_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DIGIT;
      ST_DIGIT: if (stat.digits_done) state_next = ST_BUILD;
      ST_BUILD: state_next = ST_ROUND;
      ST_ROUND: if (stat.rounds_done) state_next = ST_ADD;
      ST_ADD:   state_next = stat.second_block ? ST_DONE : ST_ROUND;
      ST_DONE:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  logic out_full;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.out_load) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end
  assign out_valid = out_full;

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIGIT: cmd.digit_step = 1'b1;
      ST_BUILD: begin
        cmd.build = 1'b1;
        cmd.block_init = 1'b1;
      end
      ST_ROUND: cmd.round_step = 1'b1;
      ST_ADD:   cmd.add_step = 1'b1;
      ST_DONE:  cmd.out_load = !out_full || !out_stall;
      default:  cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/ms1k_dp.sv @@
// ----------------------------------------------------------------------------
// ms1k_dp
// Datapath: digit extraction, message assembly, SHA-1 rounds, key output.
// ----------------------------------------------------------------------------
module ms1k_dp
  import ms1k_pkg::*;
#(
  parameter int KEY_HEX_CHARS = KeyHexCharsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [23:0] mac_low,
  output stat_t       stat,
  output logic [39:0] key_head,
  output logic [63:0] key_tail
);

  localparam logic [255:0] Phrase = "Although your world wonders me, ";

  logic [31:0]   val;
  logic [3:0]    dig_cnt;
  logic [319:0]  spelled;
  logic [5:0]    spell_len;
  logic [1023:0] msg;
  logic [511:0]  wwin;
  logic [6:0]    rnd;
  logic          blk;
  logic [31:0]   a, b, c, d, e;
  logic [31:0]   h0, h1, h2, h3, h4;

  logic [103:0] nib_mask;
  logic [39:0]  head_mask;
  logic [63:0]  tail_mask;

  // Digits by repeated subtraction of the current power of ten is slow; use
  // the top digit via multiply-free compare of val against k*10^7.
  logic [31:0] lead_sub [10];
  logic [3:0]  lead;
  always_comb begin
    lead = 4'd0;
    for (int j = 1; j < 10; j++) begin
      lead_sub[j] = 32'(j) * 32'd10_000_000;
      if (val >= lead_sub[j]) lead = 4'(j);
    end
    lead_sub[0] = '0;
  end

  logic [31:0] rem_x10;
  assign rem_x10 = ((val - lead_sub[lead]) << 3) + ((val - lead_sub[lead]) << 1);

  logic [9:0] len_bits;
  assign len_bits = {7'(spell_len) + 7'd32, 3'b000};

  logic [1023:0] msg_build;
  assign msg_build = ({spelled, 704'd0} | ({Phrase, 768'd0} >> {spell_len, 3'b000})
                     | ({8'h80, 1016'd0} >> len_bits))
                     | {1014'd0, len_bits};

  always_comb begin
    stat.digits_done  = (dig_cnt == 4'd7);
    stat.rounds_done  = (rnd == 7'd79);
    stat.second_block = blk;
  end

  logic [31:0] wt, wnew, f, k, t;
  assign wt   = wwin[511:480];
  assign wnew = {wwin[511-2*32 -: 32] ^ wwin[511-8*32 -: 32] ^ wwin[511-13*32 -: 32]
                ^ wwin[511 -: 32]};
  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    t = {a[26:0], a[31:27]} + f + e + k + wt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= {8'd0, mac_low} + MacOffset;
      dig_cnt <= '0;
      spelled <= '0;
      spell_len <= '0;
    end
    if (cmd.digit_step) begin
      spelled <= spelled | ({word_bytes(lead), 280'd0} >> {spell_len, 3'b000});
      spell_len <= spell_len + 6'(word_len(lead));
      val <= rem_x10;
      dig_cnt <= dig_cnt + 4'd1;
    end
    if (cmd.build) begin
      msg <= msg_build;
    end
    if (cmd.block_init) begin
      h0 <= 32'h67452301; h1 <= 32'hEFCDAB89; h2 <= 32'h98BADCFE;
      h3 <= 32'h10325476; h4 <= 32'hC3D2E1F0;
      a <= 32'h67452301; b <= 32'hEFCDAB89; c <= 32'h98BADCFE;
      d <= 32'h10325476; e <= 32'hC3D2E1F0;
      rnd <= '0;
      blk <= 1'b0;
    end
    if (cmd.build) begin
      wwin <= msg_build[1023:512];
    end
    if (cmd.round_step) begin
      a <= t; b <= a; c <= {b[1:0], b[31:2]}; d <= c; e <= d;
      wwin <= {wwin[479:0], wnew[30:0], wnew[31]};
      rnd <= rnd + 7'd1;
    end
    if (cmd.add_step) begin
      h0 <= h0 + a; h1 <= h1 + b; h2 <= h2 + c; h3 <= h3 + d; h4 <= h4 + e;
      a <= h0 + a; b <= h1 + b; c <= h2 + c; d <= h3 + d; e <= h4 + e;
      rnd <= '0;
      blk <= 1'b1;
      wwin <= msg[511:0];
    end
    if (cmd.out_load) begin
      key_head <= {h0, h1[31:24]} & head_mask;
      key_tail <= {h1[23:0], h2, h3[31:24]} & tail_mask;
    end
    if (rst) begin
      blk <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 26; i++) begin
      nib_mask[103-4*i -: 4] = (i < KEY_HEX_CHARS) ? 4'hF : 4'h0;
    end
    head_mask = nib_mask[103:64];
    tail_mask = nib_mask[63:0];
  end

endmodule

@@ rtl/core/mac_to_spelled_sha1_key.sv @@
// ----------------------------------------------------------------------------
// mac_to_spelled_sha1_key
// Spelled-digit SHA-1 key derivation from the low MAC address bytes.
// ----------------------------------------------------------------------------
// Input channel: mac_low with in_valid/in_stall. Output channel: key_head and
// key_tail with out_valid/out_stall. A transaction moves when valid is high
// and stall is low at a rising clock edge.
// One item at a time: accept, spell the 8 digits, build the message, then
// 2 x (80 rounds + 1 feed-forward) on a single SHA-1 round unit, and finally
// load the output register. The block takes no new item while one is in
// progress. The result waits in the output register while out_stall is high;
// the next item is taken once that register is free to be refilled.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
// Digest nibbles beyond KEY_HEX_CHARS read as zero.
// ----------------------------------------------------------------------------
module mac_to_spelled_sha1_key
  import ms1k_pkg::*;
#(
  parameter int KEY_HEX_CHARS = KeyHexCharsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] mac_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [39:0] key_head,
  output logic [63:0] key_tail
);

  cmd_t  cmd;
  stat_t stat;

  ms1k_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  ms1k_dp #(.KEY_HEX_CHARS(KEY_HEX_CHARS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .mac_low(mac_low), .stat(stat),
    .key_head(key_head), .key_tail(key_tail)
  );

endmodule
